// ===== rtl/atrm_pkg.sv =====
// shared types, codes and constants of the response matcher
`timescale 1ns / 1ps
`default_nettype none

package atrm_pkg;

	// size constants
	localparam int MAX_PATTERN  = 8;
	localparam int BUFFER_DEPTH = 256;
	localparam int CAP_LIMIT    = (BUFFER_DEPTH < 256) ? BUFFER_DEPTH : 256;

	// item operations
	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_BYTE  = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	// session status codes
	typedef enum logic [1:0] {
		ST_WAIT     = 2'd0,
		ST_SUCCESS  = 2'd1,
		ST_TIMEOUT  = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_RESPONSE_TIMEOUT = 3'd0,
		REG_GAP_TIMEOUT      = 3'd1,
		REG_BUFFER_LENGTH    = 3'd2,
		REG_PATTERN_LENGTH   = 3'd3,
		REG_PATTERN_BYTES    = 3'd4
	} reg_idx_t;

	// configuration register set
	typedef struct packed {
		logic [23:0] response_timeout;
		logic [15:0] gap_timeout;
		logic [8:0]  buffer_length;
		logic [3:0]  pattern_length;
		logic [63:0] pattern_bytes;
	} atrm_cfg_t;

	// session state
	typedef struct packed {
		logic        active;
		logic        seen_first;
		logic [8:0]  kept;
		logic [23:0] resp_elapsed;
		logic [15:0] gap_elapsed;
		logic [63:0] recent;
	} atrm_state_t;

	// one result item
	typedef struct packed {
		logic       store_valid;
		logic [7:0] store_index;
		logic [7:0] store_byte;
		logic       done_res;
		status_t    status;
		logic [7:0] response_length;
	} atrm_result_t;

endpackage

`default_nettype wire

// ===== rtl/atrm_step.sv =====
// next-state and result logic for one item of the response matcher
`timescale 1ns / 1ps
`default_nettype none

module atrm_step
	import atrm_pkg::*;
(
	input  wire atrm_cfg_t    cfg,
	input  wire atrm_state_t  cur,
	input  wire logic [1:0]   operation,
	input  wire logic [7:0]   rx_byte,
	output atrm_state_t       nxt,
	output atrm_result_t      res
);

	logic [8:0]              cap;
	logic [8:0]              last_slot;
	logic [3:0]              plen;
	logic [63:0]             shifted;
	logic [8:0]              kept_inc;
	logic [MAX_PATTERN-1:0]  byte_match;
	logic                    hit;
	logic                    timed_out;
	logic [23:0]             resp_inc;
	logic [15:0]             gap_inc;

	// effective buffer capacity and pattern length
	always_comb begin
		cap = (cfg.buffer_length > 9'(CAP_LIMIT)) ? 9'(CAP_LIMIT) : cfg.buffer_length;
		if (cap == 9'd0) begin
			cap = 9'd1;
		end
		last_slot = cap - 9'd1;
		plen = (cfg.pattern_length > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : cfg.pattern_length;
	end

	// pattern compare on the history after taking the new byte
	assign shifted  = {cur.recent[55:0], rx_byte};
	assign kept_inc = cur.kept + 9'd1;

	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			byte_match[i] = (4'(i) >= plen) ||
				(shifted[i*8 +: 8] == cfg.pattern_bytes[i*8 +: 8]);
		end
	end

	assign hit = (plen != 4'd0) && (kept_inc >= {5'd0, plen}) && (&byte_match);

	// saturating timer advance and timeout check
	assign resp_inc = (cur.resp_elapsed != 24'hFFFFFF) ? cur.resp_elapsed + 24'd1
		: cur.resp_elapsed;
	assign gap_inc  = (cur.seen_first && cur.gap_elapsed != 16'hFFFF)
		? cur.gap_elapsed + 16'd1 : cur.gap_elapsed;
	assign timed_out = (resp_inc >= cfg.response_timeout) ||
		(cur.seen_first && gap_inc >= cfg.gap_timeout);

	// state update and result per operation
	always_comb begin
		nxt = cur;
		res.store_valid = 1'b0;
		res.store_index = 8'd0;
		res.store_byte  = 8'd0;
		res.done_res    = 1'b0;
		res.status      = ST_WAIT;
		case (operation)
			OP_START: begin
				nxt.active       = 1'b1;
				nxt.seen_first   = 1'b0;
				nxt.kept         = 9'd0;
				nxt.resp_elapsed = 24'd0;
				nxt.gap_elapsed  = 16'd0;
				nxt.recent       = 64'd0;
			end
			OP_BYTE: begin
				if (cur.active) begin
					nxt.seen_first  = 1'b1;
					nxt.gap_elapsed = 16'd0;
					if (cur.kept >= last_slot) begin
						nxt.active   = 1'b0;
						res.done_res = 1'b1;
						res.status   = ST_OVERFLOW;
					end else begin
						res.store_valid = 1'b1;
						res.store_index = cur.kept[7:0];
						res.store_byte  = rx_byte;
						nxt.kept        = kept_inc;
						nxt.recent      = shifted;
						if (hit) begin
							nxt.active   = 1'b0;
							res.done_res = 1'b1;
							res.status   = ST_SUCCESS;
						end
					end
				end
			end
			OP_TICK: begin
				if (cur.active) begin
					nxt.resp_elapsed = resp_inc;
					nxt.gap_elapsed  = gap_inc;
					if (timed_out) begin
						nxt.active   = 1'b0;
						res.done_res = 1'b1;
						res.status   = (plen == 4'd0) ? ST_SUCCESS : ST_TIMEOUT;
					end
				end
			end
			default: begin
			end
		endcase
		res.response_length = nxt.kept[7:0];
	end

endmodule

`default_nettype wire

// ===== rtl/at_response_matcher_core.sv =====
// top level of the at response matcher: input register, step logic, result register
// an item passes the input register, then the result register, before its result is
// offered; throughput: one item per cycle while the output is not stalled
// an empty input register takes an item while a finished result waits to be taken
// reset: asynchronous, active low; clears the session and loads the default
// register values (timeouts 1000 and 100, buffer length 256, no pattern)
`timescale 1ns / 1ps
`default_nettype none

module at_response_matcher_core
	import atrm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	// input channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  rx_byte,
	// output channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             store_valid,
	output logic [7:0]       store_index,
	output logic [7:0]       store_byte,
	output logic             done_res,
	output logic [1:0]       status,
	output logic [7:0]       response_length
);

	atrm_cfg_t    cfg_q;
	atrm_state_t  state_q;
	atrm_state_t  state_nxt;
	atrm_result_t res_nxt;
	atrm_result_t res_s2;
	logic         valid_s1;
	logic [1:0]   op_s1;
	logic [7:0]   byte_s1;
	logic         valid_s2;
	logic         advance;
	logic         in_xfer;

	// handshake control
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.response_timeout <= 24'd1000;
			cfg_q.gap_timeout      <= 16'd100;
			cfg_q.buffer_length    <= 9'd256;
			cfg_q.pattern_length   <= 4'd0;
			cfg_q.pattern_bytes    <= 64'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESPONSE_TIMEOUT: cfg_q.response_timeout <= cfg_data[23:0];
				REG_GAP_TIMEOUT:      cfg_q.gap_timeout      <= cfg_data[15:0];
				REG_BUFFER_LENGTH:    cfg_q.buffer_length    <= cfg_data[8:0];
				REG_PATTERN_LENGTH:   cfg_q.pattern_length   <= cfg_data[3:0];
				REG_PATTERN_BYTES:    cfg_q.pattern_bytes    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1   <= operation;
			byte_s1 <= rx_byte;
		end
	end

	// per-item logic
	atrm_step u_step (
		.cfg       (cfg_q),
		.cur       (state_q),
		.operation (op_s1),
		.rx_byte   (byte_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	// output ports
	assign out_valid       = valid_s2;
	assign store_valid     = res_s2.store_valid;
	assign store_index     = res_s2.store_index;
	assign store_byte      = res_s2.store_byte;
	assign done_res        = res_s2.done_res;
	assign status          = res_s2.status;
	assign response_length = res_s2.response_length;

endmodule

`default_nettype wire
